FILE: hdl/tshnm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tshnm_pkg;

    localparam int SLOTS        = 16;
    localparam int SLOT_W       = $clog2(SLOTS);
    localparam int CNT_W        = $clog2(SLOTS + 1);
    localparam int STAMP_W      = 32;
    localparam int SLOT_FIELD_W = 4;

    localparam logic [STAMP_W-1:0] MAX_GAP_RESET = 32'd400000;
    localparam logic [CNT_W-1:0]   SLOTS_CNT     = CNT_W'(SLOTS);
    localparam logic [SLOT_W-1:0]  LAST_SLOT     = SLOT_W'(SLOTS - 1);

    typedef enum logic {
        KIND_SAVE = 1'b0,
        KIND_FIND = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [STAMP_W-1:0]  stamp;
    } t_in;

    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] slot;
        logic                    hit;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              init;
        logic              valid;
        logic [SLOT_W-1:0] idx;
    } t_cmp_ctl;

    // low bits of a slot number, zero-extended when the index is narrower
    function automatic logic [SLOT_FIELD_W-1:0] slot_field(input logic [SLOT_W-1:0] idx);
        logic [SLOT_W+SLOT_FIELD_W-1:0] ext;
        ext = {{SLOT_FIELD_W{1'b0}}, idx};
        return ext[SLOT_FIELD_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/tshnm_store.sv
`timescale 1ns / 1ps
`default_nettype none

module tshnm_store (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [tshnm_pkg::SLOT_W-1:0]  i_waddr,
    input  wire logic [tshnm_pkg::STAMP_W-1:0] i_wdata,
    input  wire logic [tshnm_pkg::SLOT_W-1:0]  i_raddr,
    output logic      [tshnm_pkg::STAMP_W-1:0] o_rdata
);
    import tshnm_pkg::*;

    logic [STAMP_W-1:0] r_mem [SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hdl/tshnm_cmp.sv
`timescale 1ns / 1ps
`default_nettype none

module tshnm_cmp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tshnm_pkg::t_cmp_ctl           i_ctl,
    input  wire logic [tshnm_pkg::STAMP_W-1:0] i_init_gap,
    input  wire logic [tshnm_pkg::STAMP_W-1:0] i_stored,
    input  wire logic [tshnm_pkg::STAMP_W-1:0] i_query,
    output logic                               o_busy,
    output logic      [tshnm_pkg::SLOT_W-1:0]  o_best_idx,
    output logic                               o_found
);
    import tshnm_pkg::*;

    logic               r_diff_v;
    logic [STAMP_W-1:0] r_diff;
    logic [SLOT_W-1:0]  r_diff_idx;
    logic [STAMP_W-1:0] r_best_gap;
    logic [SLOT_W-1:0]  r_best_idx;
    logic               r_found;
    logic [STAMP_W-1:0] n_diff;
    logic               n_better;

    always_comb begin
        n_diff   = (i_stored > i_query) ? (i_stored - i_query) : (i_query - i_stored);
        // strict compare keeps the oldest slot on a tie
        n_better = r_diff_v && (r_diff < r_best_gap);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff_v <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_diff_v <= i_ctl.valid;
            if (i_ctl.init) begin
                r_found <= 1'b0;
            end else if (n_better) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_diff     <= n_diff;
        r_diff_idx <= i_ctl.idx;
        if (i_ctl.init) begin
            r_best_gap <= i_init_gap;
            r_best_idx <= '0;
        end else if (n_better) begin
            r_best_gap <= r_diff;
            r_best_idx <= r_diff_idx;
        end
    end

    assign o_busy     = r_diff_v;
    assign o_best_idx = r_best_idx;
    assign o_found    = r_found;

endmodule

`default_nettype wire

FILE: hdl/timestamp_history_nearest_match.sv
`timescale 1ns / 1ps
`default_nettype none

// Ring history of snapshot time stamps. A save item stores its stamp at the
// head slot and returns that slot with hit set; a find item returns the
// oldest slot whose stamp lies strictly nearest the query and strictly within
// max_gap, or slot 0 with hit clear. One item is worked at a time: a save
// passes through the done state to the result register, and a find walks
// the filled slots, oldest first, through the single difference-and-compare
// unit, one stored stamp per cycle, read through the registered read port
// of the stamp memory, before it goes the same way. The input is ready again
// once the result register is loaded.
module timestamp_history_nearest_match (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire tshnm_pkg::t_in                i_item,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output tshnm_pkg::t_out                    o_item,
    input  wire logic                          i_cfg_we,
    input  wire logic [tshnm_pkg::STAMP_W-1:0] i_cfg_data
);
    import tshnm_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [STAMP_W-1:0] r_max_gap;
    logic [SLOT_W-1:0]  r_head;
    logic [CNT_W-1:0]   r_fill;
    logic [CNT_W-1:0]   r_iss;
    logic [SLOT_W-1:0]  r_ptr;
    logic               r_rd_v;
    logic [SLOT_W-1:0]  r_rd_idx;
    t_kind              r_kind;
    logic [STAMP_W-1:0] r_query;
    t_out               r_res;
    logic               r_out_v;
    t_out               r_out;

    logic               in_acc;
    logic               walk_issue;
    logic               res_push;
    logic               mem_we;
    logic [CNT_W-1:0]   head_ext;
    logic [SLOT_W-1:0]  start;
    logic [STAMP_W-1:0] rdata;
    t_cmp_ctl           cmp_ctl;
    logic               cmp_busy;
    logic [SLOT_W-1:0]  best_idx;
    logic               found;
    t_out               res;

    assign in_acc   = i_valid && o_ready;
    assign mem_we   = in_acc && (i_item.kind == KIND_SAVE);
    assign head_ext = CNT_W'(r_head);

    // oldest filled slot: head minus fill, wrapped
    always_comb begin
        if (head_ext >= r_fill) begin
            start = SLOT_W'(head_ext - r_fill);
        end else begin
            start = SLOT_W'(SLOTS_CNT - (r_fill - head_ext));
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_item.kind == KIND_SAVE) ? S_DONE : S_WALK;
                end
            end
            S_WALK: begin
                if ((r_iss == r_fill) && !r_rd_v && !cmp_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_v || i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready    = 1'b0;
        walk_issue = 1'b0;
        res_push   = 1'b0;
        unique case (r_state)
            S_IDLE:  o_ready    = 1'b1;
            S_WALK:  walk_issue = (r_iss != r_fill);
            S_DONE:  res_push   = !r_out_v || i_ready;
            default: o_ready    = 1'b0;
        endcase
    end

    always_comb begin
        if (r_kind == KIND_FIND) begin
            res.slot = slot_field(best_idx);
            res.hit  = found;
        end else begin
            res = r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_max_gap <= MAX_GAP_RESET;
            r_head    <= '0;
            r_fill    <= '0;
            r_iss     <= '0;
            r_rd_v    <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= walk_issue;
            if (i_cfg_we) begin
                r_max_gap <= i_cfg_data;
            end
            if (mem_we) begin
                r_head <= (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
                if (r_fill != SLOTS_CNT) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (in_acc) begin
                r_iss <= '0;
            end else if (walk_issue) begin
                r_iss <= r_iss + 1'b1;
            end
            if (res_push) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_ptr;
        if (in_acc) begin
            r_kind   <= i_item.kind;
            r_query  <= i_item.stamp;
            r_ptr    <= start;
            r_res.slot <= slot_field(r_head);
            r_res.hit  <= 1'b1;
        end else if (walk_issue) begin
            r_ptr <= (r_ptr == LAST_SLOT) ? '0 : r_ptr + 1'b1;
        end
        if (res_push) begin
            r_out <= res;
        end
    end

    assign cmp_ctl.init  = in_acc && (i_item.kind == KIND_FIND);
    assign cmp_ctl.valid = r_rd_v;
    assign cmp_ctl.idx   = r_rd_idx;

    tshnm_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_head),
        .i_wdata (i_item.stamp),
        .i_raddr (r_ptr),
        .o_rdata (rdata)
    );

    tshnm_cmp u_cmp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (cmp_ctl),
        .i_init_gap (r_max_gap),
        .i_stored   (rdata),
        .i_query    (r_query),
        .o_busy     (cmp_busy),
        .o_best_idx (best_idx),
        .o_found    (found)
    );

    assign o_valid = r_out_v;
    assign o_item  = r_out;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= SLOTS_CNT)
        else $error("fill count beyond slot count");

    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iss <= r_fill)
        else $error("walk read past filled slots");

    a_save_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> (r_state == S_DONE) && (r_head != $past(r_head)))
        else $error("save item did not advance head");

endmodule

`default_nettype wire
